/* hw/rtl/pvd_pkg.sv */
// Shared types, constants and the sine table for the planar vehicle dynamics step unit.
package pvd_pkg;

	localparam int SINE_TABLE_ADDR_BITS = 10;
	localparam int ROM_SIZE = 1 << SINE_TABLE_ADDR_BITS;
	localparam int QUARTER = ROM_SIZE >> 2;

	typedef struct packed {
		logic signed [15:0] thrust_x;
		logic signed [15:0] thrust_y;
		logic signed [15:0] thrust_yaw;
		logic [15:0]        tick_length;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        heading;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_yaw;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} seq_state_t;

	// Operand pairs presented to the shared multiplier.
	typedef enum logic [4:0] {
		MS_NONE,
		MS_DT_DT,
		MS_GX_TX,
		MS_DX_VX,
		MS_GY_TY,
		MS_DY_VY,
		MS_GW_TW,
		MS_DW_VW,
		MS_VX_DT,
		MS_AX_DT2,
		MS_VY_DT,
		MS_AY_DT2,
		MS_VW_DT,
		MS_AW_DT2,
		MS_AX_DT,
		MS_C_DBX,
		MS_S_DBY,
		MS_S_DBX,
		MS_C_DBY,
		MS_AY_DT,
		MS_AW_DT,
		MS_DBW_K
	} mul_sel_t;

	typedef enum logic [2:0] {
		AO_HOLD,
		AO_LOAD,
		AO_LOAD2,
		AO_ADD,
		AO_SUB
	} acc_op_t;

	typedef enum logic [3:0] {
		WB_NONE,
		WB_DT2,
		WB_AX,
		WB_AY,
		WB_AW,
		WB_DBX,
		WB_DBY,
		WB_DBW,
		WB_VX,
		WB_POSX,
		WB_POSY,
		WB_VY,
		WB_VW_HDG
	} wb_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		wb_sel_t  wb_sel;
		logic     start;
		logic     load_out;
	} ctl_t;

	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 31;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int SUM_W = 60;

	typedef logic signed [17:0] sine_t;
	typedef sine_t sine_rom_t [ROM_SIZE];

	// Unsigned quotient by restoring shift and subtract, used only to build the table.
	function automatic longint unsigned udiv64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= d) begin
				rem = rem - d;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Sine of 2*pi*r/ROM_SIZE for r in the first quadrant, Q1.16, by Taylor series in Q30.
	function automatic sine_t quarter_sine(input int unsigned r);
		longint unsigned x;
		longint unsigned term;
		longint unsigned dvs;
		longint          sum;
		x = (64'(r) * 64'd6746518852) >> SINE_TABLE_ADDR_BITS;
		term = x;
		sum = longint'(x);
		for (int i = 1; i <= 7; i++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			dvs = 64'((2 * i) * (2 * i + 1));
			term = udiv64(term, dvs);
			if ((i % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return sine_t'((sum + 64'sd8192) >>> 14);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		int unsigned q;
		int unsigned r;
		sine_t       v;
		for (int k = 0; k < ROM_SIZE; k++) begin
			q = k >> (SINE_TABLE_ADDR_BITS - 2);
			r = k & (QUARTER - 1);
			v = (q[0]) ? quarter_sine(QUARTER - r) : quarter_sine(r);
			rom[k] = (q[1]) ? -v : v;
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* hw/rtl/pvd_sine_rom.sv */
// Registered sine and cosine lookup of the heading angle.
module pvd_sine_rom (
	input  logic                clk,
	input  logic [31:0]         angle,
	output pvd_pkg::sine_t      sin_q,
	output pvd_pkg::sine_t      cos_q
);
	import pvd_pkg::*;

	logic [31:0] angle_c;

	// Cosine is the sine a quarter turn ahead.
	assign angle_c = angle + 32'h4000_0000;

	always_ff @(posedge clk) begin
		sin_q <= SINE_ROM[angle[31 -: SINE_TABLE_ADDR_BITS]];
		cos_q <= SINE_ROM[angle_c[31 -: SINE_TABLE_ADDR_BITS]];
	end

endmodule

/* hw/rtl/pvd_mac.sv */
// Shared multiplier with a registered product and a wide accumulator.
module pvd_mac (
	input  logic                                 clk,
	input  logic signed [pvd_pkg::MUL_A_W-1:0]   mul_a,
	input  logic signed [pvd_pkg::MUL_B_W-1:0]   mul_b,
	input  pvd_pkg::acc_op_t                     acc_op,
	output logic signed [pvd_pkg::PROD_W-1:0]    prod_q,
	output logic signed [pvd_pkg::SUM_W-1:0]     sum_q
);
	import pvd_pkg::*;

	logic signed [SUM_W-1:0] p_trunc;

	assign p_trunc = prod_q[SUM_W-1:0];

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		case (acc_op)
			AO_LOAD:  sum_q <= p_trunc;
			AO_LOAD2: sum_q <= p_trunc <<< 1;
			AO_ADD:   sum_q <= sum_q + p_trunc;
			AO_SUB:   sum_q <= sum_q - p_trunc;
			default:  sum_q <= sum_q;
		endcase
	end

endmodule

/* hw/rtl/pvd_ctrl.sv */
// Sequencer that steps the shared multiplier through one tick of integration.
module pvd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          res_ready,
	output logic          cmd_ready,
	output logic          res_valid,
	output pvd_pkg::ctl_t ctl
);
	import pvd_pkg::*;

	localparam logic [4:0] STEP_LAST = 5'd21;

	seq_state_t state_q;
	seq_state_t state_d;
	logic [4:0] step_q;
	logic       res_valid_q;
	logic       out_free;

	assign out_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (step_q == STEP_LAST) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == ST_IDLE);
		ctl.start = (state_q == ST_IDLE) && cmd_valid;
		ctl.load_out = (state_q == ST_WAIT) && out_free;
		ctl.mul_sel = MS_NONE;
		ctl.acc_op = AO_HOLD;
		ctl.wb_sel = WB_NONE;
		// Steps 0 to 20 each issue one product; steps 1 to 20 fold in the one issued a step earlier.
		// Write-backs read the accumulator as it stood before this step.
		if (state_q == ST_RUN) begin
			case (step_q)
				5'd0: begin
					ctl.mul_sel = MS_DT_DT;
				end
				5'd1: begin
					ctl.mul_sel = MS_GX_TX; ctl.acc_op = AO_LOAD;
				end
				5'd2: begin
					ctl.mul_sel = MS_DX_VX; ctl.acc_op = AO_LOAD; ctl.wb_sel = WB_DT2;
				end
				5'd3: begin
					ctl.mul_sel = MS_GY_TY; ctl.acc_op = AO_SUB;
				end
				5'd4: begin
					ctl.mul_sel = MS_DY_VY; ctl.acc_op = AO_LOAD; ctl.wb_sel = WB_AX;
				end
				5'd5: begin
					ctl.mul_sel = MS_GW_TW; ctl.acc_op = AO_SUB;
				end
				5'd6: begin
					ctl.mul_sel = MS_DW_VW; ctl.acc_op = AO_LOAD; ctl.wb_sel = WB_AY;
				end
				5'd7: begin
					ctl.mul_sel = MS_VX_DT; ctl.acc_op = AO_SUB;
				end
				5'd8: begin
					ctl.mul_sel = MS_AX_DT2; ctl.acc_op = AO_LOAD2; ctl.wb_sel = WB_AW;
				end
				5'd9: begin
					ctl.mul_sel = MS_VY_DT; ctl.acc_op = AO_ADD;
				end
				5'd10: begin
					ctl.mul_sel = MS_AY_DT2; ctl.acc_op = AO_LOAD2; ctl.wb_sel = WB_DBX;
				end
				5'd11: begin
					ctl.mul_sel = MS_VW_DT; ctl.acc_op = AO_ADD;
				end
				5'd12: begin
					ctl.mul_sel = MS_AW_DT2; ctl.acc_op = AO_LOAD2; ctl.wb_sel = WB_DBY;
				end
				5'd13: begin
					ctl.mul_sel = MS_AX_DT; ctl.acc_op = AO_ADD;
				end
				5'd14: begin
					ctl.mul_sel = MS_C_DBX; ctl.acc_op = AO_LOAD; ctl.wb_sel = WB_DBW;
				end
				5'd15: begin
					ctl.mul_sel = MS_S_DBY; ctl.acc_op = AO_LOAD; ctl.wb_sel = WB_VX;
				end
				5'd16: begin
					ctl.mul_sel = MS_S_DBX; ctl.acc_op = AO_SUB;
				end
				5'd17: begin
					ctl.mul_sel = MS_C_DBY; ctl.acc_op = AO_LOAD; ctl.wb_sel = WB_POSX;
				end
				5'd18: begin
					ctl.mul_sel = MS_AY_DT; ctl.acc_op = AO_ADD;
				end
				5'd19: begin
					ctl.mul_sel = MS_AW_DT; ctl.acc_op = AO_LOAD; ctl.wb_sel = WB_POSY;
				end
				5'd20: begin
					ctl.mul_sel = MS_DBW_K; ctl.acc_op = AO_LOAD; ctl.wb_sel = WB_VY;
				end
				5'd21: begin
					ctl.wb_sel = WB_VW_HDG;
				end
				default: begin
					ctl.mul_sel = MS_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN) begin
				step_q <= step_q + 5'd1;
			end else begin
				step_q <= '0;
			end
			if (ctl.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/planar_vehicle_dynamics_step_unit.sv */
// Top level of the planar vehicle dynamics step unit: registers, state and operand routing.
// A result is offered after its input transfer once the 22 sequencer steps have run and the
// output register is loaded; the steps are set by the 21 products of the shared multiplier.
// A new tick is taken only once the last one has run; a finished result may wait while the next tick runs.
// Reset clears pose and velocities to zero and loads the gains with 1.0 and damping with 0.
module planar_vehicle_dynamics_step_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  pvd_pkg::in_item_t   cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output pvd_pkg::out_item_t  res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import pvd_pkg::*;

	typedef enum logic [2:0] {
		REG_GAIN_X,
		REG_GAIN_Y,
		REG_GAIN_YAW,
		REG_DAMP_X,
		REG_DAMP_Y,
		REG_DAMP_YAW
	} reg_idx_t;

	localparam logic signed [MUL_B_W-1:0] RAD_TO_BAM = 31'sd683565276;

	ctl_t ctl;

	logic [23:0] gain_x_q, gain_y_q, gain_yaw_q;
	logic [23:0] damp_x_q, damp_y_q, damp_yaw_q;

	logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, vel_yaw_q;
	logic [31:0]        hdg_q;

	in_item_t           item_q;
	out_item_t          res_q;
	logic [15:0]        dt2_q;
	logic signed [31:0] ax_q, ay_q, aw_q;
	logic signed [33:0] dbx_q, dby_q, dbw_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SUM_W-1:0]   rs16;
	logic signed [SUM_W-1:0]   rs17;
	logic [47:0]               turn;
	sine_t                     sin_q, cos_q;
	logic                      wr_en;
	reg_idx_t                  wr_idx;
	reg_idx_t                  rd_idx;

	function automatic logic signed [SUM_W-1:0] rnd16(input logic signed [SUM_W-1:0] v);
		return (v + 60'sd32768) >>> 16;
	endfunction

	function automatic logic signed [SUM_W-1:0] rnd17(input logic signed [SUM_W-1:0] v);
		return (v + 60'sd65536) >>> 17;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [60:0] v);
		if (v > 61'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -61'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	pvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.res_ready (res_ready),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.ctl       (ctl)
	);

	pvd_mac u_mac (
		.clk    (clk),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.acc_op (ctl.acc_op),
		.prod_q (prod_q),
		.sum_q  (sum_q)
	);

	pvd_sine_rom u_sine (
		.clk   (clk),
		.angle (hdg_q),
		.sin_q (sin_q),
		.cos_q (cos_q)
	);

	assign rs16 = rnd16(sum_q);
	assign rs17 = rnd17(sum_q);
	assign turn = prod_q[47:0] + 48'd32768;
	assign res = res_q;

	// Configuration port
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign wr_idx = reg_idx_t'(paddr[4:2]);
	assign rd_idx = reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (rd_idx)
			REG_GAIN_X:   prdata = {8'd0, gain_x_q};
			REG_GAIN_Y:   prdata = {8'd0, gain_y_q};
			REG_GAIN_YAW: prdata = {8'd0, gain_yaw_q};
			REG_DAMP_X:   prdata = {8'd0, damp_x_q};
			REG_DAMP_Y:   prdata = {8'd0, damp_y_q};
			REG_DAMP_YAW: prdata = {8'd0, damp_yaw_q};
			default:      prdata = '0;
		endcase
	end

	// Operand routing for the shared multiplier. Thrust enters pre-scaled by 2^8.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.mul_sel)
			MS_DT_DT: begin
				mul_a = $signed({19'd0, item_q.tick_length});
				mul_b = $signed({15'd0, item_q.tick_length});
			end
			MS_GX_TX: begin
				mul_a = $signed({11'd0, gain_x_q});
				mul_b = $signed({{7{item_q.thrust_x[15]}}, item_q.thrust_x, 8'd0});
			end
			MS_GY_TY: begin
				mul_a = $signed({11'd0, gain_y_q});
				mul_b = $signed({{7{item_q.thrust_y[15]}}, item_q.thrust_y, 8'd0});
			end
			MS_GW_TW: begin
				mul_a = $signed({11'd0, gain_yaw_q});
				mul_b = $signed({{7{item_q.thrust_yaw[15]}}, item_q.thrust_yaw, 8'd0});
			end
			MS_DX_VX: begin
				mul_a = MUL_A_W'(vel_x_q);
				mul_b = $signed({7'd0, damp_x_q});
			end
			MS_DY_VY: begin
				mul_a = MUL_A_W'(vel_y_q);
				mul_b = $signed({7'd0, damp_y_q});
			end
			MS_DW_VW: begin
				mul_a = MUL_A_W'(vel_yaw_q);
				mul_b = $signed({7'd0, damp_yaw_q});
			end
			MS_VX_DT: begin
				mul_a = MUL_A_W'(vel_x_q);
				mul_b = $signed({15'd0, item_q.tick_length});
			end
			MS_VY_DT: begin
				mul_a = MUL_A_W'(vel_y_q);
				mul_b = $signed({15'd0, item_q.tick_length});
			end
			MS_VW_DT: begin
				mul_a = MUL_A_W'(vel_yaw_q);
				mul_b = $signed({15'd0, item_q.tick_length});
			end
			MS_AX_DT2: begin
				mul_a = MUL_A_W'(ax_q);
				mul_b = $signed({15'd0, dt2_q});
			end
			MS_AY_DT2: begin
				mul_a = MUL_A_W'(ay_q);
				mul_b = $signed({15'd0, dt2_q});
			end
			MS_AW_DT2: begin
				mul_a = MUL_A_W'(aw_q);
				mul_b = $signed({15'd0, dt2_q});
			end
			MS_AX_DT: begin
				mul_a = MUL_A_W'(ax_q);
				mul_b = $signed({15'd0, item_q.tick_length});
			end
			MS_AY_DT: begin
				mul_a = MUL_A_W'(ay_q);
				mul_b = $signed({15'd0, item_q.tick_length});
			end
			MS_AW_DT: begin
				mul_a = MUL_A_W'(aw_q);
				mul_b = $signed({15'd0, item_q.tick_length});
			end
			MS_C_DBX: begin
				mul_a = MUL_A_W'(dbx_q);
				mul_b = MUL_B_W'(cos_q);
			end
			MS_S_DBY: begin
				mul_a = MUL_A_W'(dby_q);
				mul_b = MUL_B_W'(sin_q);
			end
			MS_S_DBX: begin
				mul_a = MUL_A_W'(dbx_q);
				mul_b = MUL_B_W'(sin_q);
			end
			MS_C_DBY: begin
				mul_a = MUL_A_W'(dby_q);
				mul_b = MUL_B_W'(cos_q);
			end
			MS_DBW_K: begin
				mul_a = MUL_A_W'(dbw_q);
				mul_b = RAD_TO_BAM;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Configuration registers and the held pose and velocities.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q <= 24'd65536;
			gain_y_q <= 24'd65536;
			gain_yaw_q <= 24'd65536;
			damp_x_q <= '0;
			damp_y_q <= '0;
			damp_yaw_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			hdg_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			vel_yaw_q <= '0;
		end else begin
			if (wr_en) begin
				case (wr_idx)
					REG_GAIN_X:   gain_x_q <= pwdata[23:0];
					REG_GAIN_Y:   gain_y_q <= pwdata[23:0];
					REG_GAIN_YAW: gain_yaw_q <= pwdata[23:0];
					REG_DAMP_X:   damp_x_q <= pwdata[23:0];
					REG_DAMP_Y:   damp_y_q <= pwdata[23:0];
					REG_DAMP_YAW: damp_yaw_q <= pwdata[23:0];
					default:      gain_x_q <= gain_x_q;
				endcase
			end
			case (ctl.wb_sel)
				WB_VX:   vel_x_q <= sat32(61'(vel_x_q) + 61'(rs16));
				WB_VY:   vel_y_q <= sat32(61'(vel_y_q) + 61'(rs16));
				WB_POSX: pos_x_q <= sat32(61'(pos_x_q) + 61'(rs16));
				WB_POSY: pos_y_q <= sat32(61'(pos_y_q) + 61'(rs16));
				WB_VW_HDG: begin
					vel_yaw_q <= sat32(61'(vel_yaw_q) + 61'(rs16));
					hdg_q <= hdg_q + turn[47:16];
				end
				default: hdg_q <= hdg_q;
			endcase
		end
	end

	// Working values of the tick in progress and the output register.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			item_q <= cmd;
		end
		if (ctl.load_out) begin
			res_q.pos_x <= pos_x_q;
			res_q.pos_y <= pos_y_q;
			res_q.heading <= hdg_q;
			res_q.vel_x <= vel_x_q;
			res_q.vel_y <= vel_y_q;
			res_q.vel_yaw <= vel_yaw_q;
		end
		case (ctl.wb_sel)
			WB_DT2:  dt2_q <= rs16[15:0];
			WB_AX:   ax_q <= sat32(61'(rs16));
			WB_AY:   ay_q <= sat32(61'(rs16));
			WB_AW:   aw_q <= sat32(61'(rs16));
			WB_DBX:  dbx_q <= rs17[33:0];
			WB_DBY:  dby_q <= rs17[33:0];
			WB_DBW:  dbw_q <= rs17[33:0];
			default: dt2_q <= dt2_q;
		endcase
	end

endmodule

/* tb/sv/planar_vehicle_dynamics_step_unit_test.sv */
// Self-checking testbench for the planar vehicle dynamics step unit.
`timescale 1ns / 100ps

module planar_vehicle_dynamics_step_unit_test;
	import pvd_pkg::*;

	localparam int TAB_BITS = pvd_pkg::SINE_TABLE_ADDR_BITS;
	localparam int TAB_SIZE = 1 << TAB_BITS;
	localparam int NUM_REGS = 6;
	localparam int RANDOM_PER_SET = 235;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_OFF_CYCLES = 400;

	localparam logic [4:0] ADDR_GAIN_X = 5'd0;
	localparam logic [4:0] ADDR_GAIN_Y = 5'd4;
	localparam logic [4:0] ADDR_GAIN_YAW = 5'd8;
	localparam logic [4:0] ADDR_DAMP_X = 5'd12;
	localparam logic [4:0] ADDR_DAMP_Y = 5'd16;
	localparam logic [4:0] ADDR_DAMP_YAW = 5'd20;
	localparam logic [4:0] ADDR_UNUSED_A = 5'd24;
	localparam logic [4:0] ADDR_UNUSED_B = 5'd28;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	in_item_t    cmd;
	logic        res_valid;
	logic        res_ready;
	out_item_t   res;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	planar_vehicle_dynamics_step_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: gains and damping, then pose and velocities.
	logic [23:0] gain_reg [NUM_REGS];
	logic signed [31:0] px, py, vx, vy, vw;
	logic [31:0] hdg;
	longint sine_tab [TAB_SIZE];

	out_item_t pose_queue [$];
	int errors = 0;
	int results_seen = 0;
	int ticks_sent = 0;
	int cycles = 0;
	int sender_idle = 0;
	int recv_idle = 0;
	bit hold_req = 0;
	int hold_left = 0;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t pose;
	} stim_row_t;

	stim_row_t directed [$];

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("planar_vehicle_dynamics_step_unit_test NOT OK");
			$finish;
		end
	end

	function automatic longint quarter_val(int r);
		longint unsigned x;
		longint unsigned term;
		longint          acc;
		x = (longint'(r) * 64'd6746518852) >> TAB_BITS;
		term = x;
		acc = longint'(x);
		for (int i = 1; i <= 7; i++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / longint'((2 * i) * (2 * i + 1));
			if (i % 2 == 1) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		return (acc + 8192) >>> 14;
	endfunction

	function automatic longint round_shift(longint x, int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint x);
		if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] axis_accel(logic [23:0] g, logic [23:0] d,
			logic signed [15:0] thrust, logic signed [31:0] v);
		longint drive;
		longint drag;
		drive = longint'(g) * longint'(thrust) * 256;
		drag = longint'(d) * longint'(v);
		return clamp32(round_shift(drive - drag, 16));
	endfunction

	function automatic longint axis_disp(logic signed [31:0] v, logic signed [31:0] a,
			longint dt, longint dt2);
		return round_shift(2 * longint'(v) * dt + longint'(a) * dt2, 17);
	endfunction

	// Advances the predicted body by one tick and returns the new pose.
	function automatic out_item_t integrate_tick(in_item_t it);
		longint dt, dt2, dbx, dby, dbw, s, c;
		logic signed [31:0] ax, ay, aw;
		longint unsigned turn;
		logic [31:0] cos_angle;
		out_item_t o;
		dt = longint'(it.tick_length);
		dt2 = (dt * dt + 32768) >> 16;
		ax = axis_accel(gain_reg[0], gain_reg[3], it.thrust_x, vx);
		ay = axis_accel(gain_reg[1], gain_reg[4], it.thrust_y, vy);
		aw = axis_accel(gain_reg[2], gain_reg[5], it.thrust_yaw, vw);
		dbx = axis_disp(vx, ax, dt, dt2);
		dby = axis_disp(vy, ay, dt, dt2);
		dbw = axis_disp(vw, aw, dt, dt2);
		cos_angle = hdg + 32'h40000000;
		s = sine_tab[hdg >> (32 - TAB_BITS)];
		c = sine_tab[cos_angle >> (32 - TAB_BITS)];
		px = clamp32(longint'(px) + round_shift(c * dbx - s * dby, 16));
		py = clamp32(longint'(py) + round_shift(s * dbx + c * dby, 16));
		turn = longint'(dbw) * 64'd683565276 + 64'd32768;
		hdg = hdg + turn[47:16];
		vx = clamp32(longint'(vx) + round_shift(longint'(ax) * dt, 16));
		vy = clamp32(longint'(vy) + round_shift(longint'(ay) * dt, 16));
		vw = clamp32(longint'(vw) + round_shift(longint'(aw) * dt, 16));
		o.pos_x = px;
		o.pos_y = py;
		o.heading = hdg;
		o.vel_x = vx;
		o.vel_y = vy;
		o.vel_yaw = vw;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
		errors++;
	endtask

	task automatic check_pose(out_item_t got);
		out_item_t want;
		if (pose_queue.size() == 0) begin
			report_mismatch("result with none pending", got.pos_x, 32'h0);
			return;
		end
		want = pose_queue.pop_front();
		results_seen++;
		if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
		if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
		if (got.heading !== want.heading) report_mismatch("heading", got.heading, want.heading);
		if (got.vel_x !== want.vel_x) report_mismatch("vel_x", got.vel_x, want.vel_x);
		if (got.vel_y !== want.vel_y) report_mismatch("vel_y", got.vel_y, want.vel_y);
		if (got.vel_yaw !== want.vel_yaw) report_mismatch("vel_yaw", got.vel_yaw, want.vel_yaw);
	endtask

	// Result side: random ready, plus one long hold-off on request.
	initial begin
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) check_pose(res);
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_OFF_CYCLES;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Called at a rising edge; valid stays high across back-to-back transfers.
	task automatic send_tick(in_item_t it, bit typed, out_item_t pose);
		out_item_t predicted;
		while ($urandom_range(99) < sender_idle) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (!cmd_ready);
		predicted = integrate_tick(it);
		pose_queue.push_back(typed ? pose : predicted);
		ticks_sent++;
	endtask

	task automatic apb_write(logic [4:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr < ADDR_UNUSED_A) gain_reg[addr >> 2] = data[23:0];
		@(posedge clk);
	endtask

	task automatic apb_read_check(logic [4:0] addr);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[23:0] !== gain_reg[addr >> 2])
			report_mismatch("register readback", prdata, {8'h0, gain_reg[addr >> 2]});
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		cmd_valid <= 1'b0;
		while (pose_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic in_item_t mk_tick(logic [15:0] tx, logic [15:0] ty,
			logic [15:0] tw, logic [15:0] dt);
		in_item_t it;
		it.thrust_x = tx;
		it.thrust_y = ty;
		it.thrust_yaw = tw;
		it.tick_length = dt;
		return it;
	endfunction

	function automatic in_item_t random_tick();
		in_item_t it;
		it.thrust_x = 16'($urandom);
		it.thrust_y = 16'($urandom);
		it.thrust_yaw = 16'($urandom);
		case ($urandom_range(9))
			0: it.tick_length = 16'h0000;
			1: it.tick_length = 16'hFFFF;
			2, 3, 4: it.tick_length = 16'($urandom_range(16'h0400));
			default: it.tick_length = 16'($urandom);
		endcase
		return it;
	endfunction

	task automatic add_row(in_item_t it, bit typed);
		stim_row_t row;
		row.item = it;
		row.typed = typed;
		row.pose = '0;
		directed.push_back(row);
	endtask

	initial begin
		logic [23:0] setting [NUM_REGS];
		int rv;
		out_item_t none;
		none = '0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int k = 0; k < TAB_SIZE; k++) begin
			rv = (((k / (TAB_SIZE / 4)) % 2) == 1) ? (TAB_SIZE / 4) - (k % (TAB_SIZE / 4))
				: (k % (TAB_SIZE / 4));
			sine_tab[k] = quarter_val(rv);
			if ((k / (TAB_SIZE / 4)) >= 2) sine_tab[k] = -sine_tab[k];
		end
		for (int i = 0; i < NUM_REGS; i++) gain_reg[i] = (i < 3) ? 24'h010000 : 24'h0;
		px = 0; py = 0; vx = 0; vy = 0; vw = 0; hdg = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// From reset, zero-length ticks and zero thrust leave the body at rest.
		add_row(mk_tick(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000), 1);
		add_row(mk_tick(16'h0000, 16'h0000, 16'h0000, 16'hFFFF), 1);
		add_row(mk_tick(16'h8000, 16'h7FFF, 16'h8000, 16'h0000), 1);
		add_row(mk_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF), 0);
		add_row(mk_tick(16'h8000, 16'h8000, 16'h8000, 16'hFFFF), 0);
		add_row(mk_tick(16'h0100, 16'h0000, 16'h0000, 16'h0001), 0);
		add_row(mk_tick(16'h0000, 16'h0000, 16'h0100, 16'h8000), 0);
		add_row(mk_tick(16'h7FFF, 16'h0000, 16'h0000, 16'h0000), 0);
		add_row(mk_tick(16'h0000, 16'h0100, 16'h8000, 16'h4000), 0);
		add_row(mk_tick(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFE), 0);
		for (int i = 0; i < 12; i++)
			add_row(mk_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF), 0);

		foreach (directed[i]) send_tick(directed[i].item, directed[i].typed, none);
		drain();

		for (int set_idx = 0; set_idx < 6; set_idx++) begin
			sender_idle = (set_idx < 2) ? 22 : (set_idx < 4) ? 66 : 0;
			recv_idle = (set_idx < 2) ? 66 : (set_idx < 4) ? 22 : 0;
			for (int i = 0; i < NUM_REGS; i++) begin
				case (set_idx)
					0: setting[i] = 24'hFFFFFF;
					1: setting[i] = (i < 3) ? 24'hFFFFFF : 24'h0;
					2: setting[i] = (i < 3) ? 24'h0 : 24'hFFFFFF;
					3: setting[i] = 24'($urandom);
					4: setting[i] = 24'($urandom_range(24'h040000));
					default: setting[i] = (i < 3) ? 24'h010000
						: 24'($urandom_range(24'h002000));
				endcase
				apb_write(5'(4 * i), {8'($urandom), setting[i]});
			end
			// Writes outside the register map must change nothing.
			apb_write(ADDR_UNUSED_A, $urandom);
			apb_write(ADDR_UNUSED_B, 32'hFFFFFFFF);
			for (int i = 0; i < NUM_REGS; i++) apb_read_check(5'(4 * i));
			@(posedge clk);
			for (int n = 0; n < RANDOM_PER_SET; n++) begin
				if (set_idx == 4 && n == 20) hold_req = 1;
				send_tick(random_tick(), 0, none);
			end
			drain();
		end

		$display("%0d ticks sent, %0d results checked, six register settings,",
			ticks_sent, results_seen);
		$display("three idle patterns and one long result-side hold-off; %0d errors", errors);
		if (errors == 0 && pose_queue.size() == 0) begin
			$display("planar_vehicle_dynamics_step_unit_test OK");
		end else begin
			$display("planar_vehicle_dynamics_step_unit_test NOT OK");
		end
		$finish;
	end

endmodule
